// ===== rtl/rgbhsl_pkg.sv =====
// Shared types and constants for the RGB to HSL converter.
package rgbhsl_pkg;

    // Field widths fixed by the pixel and result formats.
    localparam int CHAN_W  = 8;
    localparam int HUE_W   = 15;
    localparam int SAT_W   = 16;
    localparam int LIGHT_W = 16;

    // Hue constants in units of 1/64 degree.
    localparam int unsigned HUE_SECTOR_SCALE = 3840;   // 60 degrees
    localparam int unsigned HUE_GREEN_OFFSET = 7680;   // 120 degrees
    localparam int unsigned HUE_BLUE_OFFSET  = 15360;  // 240 degrees
    localparam int unsigned HUE_FULL_CIRCLE  = 23040;  // 360 degrees

    // Divider geometry: numerators fit in 24 bits, divisors in 9 bits,
    // and every quotient fits in 16 bits.
    localparam int DIV_NUM_W     = 24;
    localparam int DIV_DEN_W     = 9;
    localparam int DIV_QUO_W     = 16;
    localparam int DIV_STEP_BITS = 2;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [HUE_W-1:0]   hue;
        logic [SAT_W-1:0]   saturation;
        logic [LIGHT_W-1:0] lightness;
    } hsl_t;

    typedef enum logic [1:0] {
        SECT_RED   = 2'd0,
        SECT_GREEN = 2'd1,
        SECT_BLUE  = 2'd2
    } sector_t;

    // Data that rides along with the hue division.
    typedef struct packed {
        logic               grey;
        logic               neg;
        sector_t            sector;
        logic [LIGHT_W-1:0] lightness;
    } hue_side_t;

endpackage

// ===== rtl/rgb_to_hsl_converter.sv =====
// Top level of the pipelined RGB to HSL pixel converter.
//
//   channel   ports              direction  beat taken when
//   pixel     start, pixel       in         start && !busy
//   result    done, result       out        done (one cycle, no back-pressure)
//
// One pixel may enter on every clock; busy is always low because nothing in the
// pipe can stall. A pixel taken at an edge passes through the stage A and
// stage B registers, the divider stages and the output register before its
// result is driven onto the result ports, and the receiver takes it at the
// edge that ends the cycle in which done is high. The latency is set by the
// two parallel pipelined dividers, which retire DIV_STEP_BITS quotient bits in
// each stage. Reset clears only the valid bits that travel with each beat;
// data registers are not reset.
module rgb_to_hsl_converter
    import rgbhsl_pkg::*;
#(
    parameter int DIV_STEP_BITS_P = DIV_STEP_BITS
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    output logic   busy,
    input  pixel_t pixel,
    output logic   done,
    output hsl_t   result
);

    localparam int DIV_STAGES = (DIV_QUO_W + DIV_STEP_BITS_P - 1) / DIV_STEP_BITS_P;
    localparam int SIDE_W     = $bits(hue_side_t);

    // The pipe never stalls, so a new beat is always welcome.
    assign busy = 1'b0;

    // ---------------------------------------------------------------------
    // Stage A: find the largest and smallest channel, the hue sector, and the
    // signed difference of the two other channels as sign and magnitude.
    // Ties go to red first, then green.
    // ---------------------------------------------------------------------
    logic              a_valid_reg;
    logic [CHAN_W-1:0] a_max_reg, a_max_next;
    logic [CHAN_W-1:0] a_min_reg, a_min_next;
    sector_t           a_sector_reg, a_sector_next;
    logic              a_neg_reg, a_neg_next;
    logic [CHAN_W-1:0] a_mag_reg, a_mag_next;

    always_comb
    begin
        logic [CHAN_W:0] diff;
        logic [CHAN_W:0] pos_op;
        logic [CHAN_W:0] neg_op;
        if (pixel.red >= pixel.green && pixel.red >= pixel.blue)
        begin
            a_sector_next = SECT_RED;
            a_max_next    = pixel.red;
            pos_op        = {1'b0, pixel.green};
            neg_op        = {1'b0, pixel.blue};
        end
        else if (pixel.green >= pixel.blue)
        begin
            a_sector_next = SECT_GREEN;
            a_max_next    = pixel.green;
            pos_op        = {1'b0, pixel.blue};
            neg_op        = {1'b0, pixel.red};
        end
        else
        begin
            a_sector_next = SECT_BLUE;
            a_max_next    = pixel.blue;
            pos_op        = {1'b0, pixel.red};
            neg_op        = {1'b0, pixel.green};
        end

        if (pixel.red <= pixel.green && pixel.red <= pixel.blue)
        begin
            a_min_next = pixel.red;
        end
        else if (pixel.green <= pixel.blue)
        begin
            a_min_next = pixel.green;
        end
        else
        begin
            a_min_next = pixel.blue;
        end

        diff       = pos_op - neg_op;
        a_neg_next = diff[CHAN_W];
        a_mag_next = a_neg_next ? CHAN_W'(neg_op - pos_op) : diff[CHAN_W-1:0];
    end

    // ---------------------------------------------------------------------
    // Stage B: chroma d, sum t, lightness, and the operands of both divisions.
    // Lightness is t * 65535 / 510, which is exactly t * 257 / 2.
    // Saturation divides d * 65535 by t, or by 510 - t in the upper half.
    // Hue divides 3840 * |difference| by d; the sign is applied afterward,
    // which matches a quotient truncated toward zero.
    // ---------------------------------------------------------------------
    logic                 b_valid_reg;
    logic [DIV_NUM_W-1:0] b_sat_num_reg, b_sat_num_next;
    logic [DIV_DEN_W-1:0] b_sat_den_reg, b_sat_den_next;
    logic [DIV_NUM_W-1:0] b_hue_num_reg, b_hue_num_next;
    logic [DIV_DEN_W-1:0] b_hue_den_reg, b_hue_den_next;
    hue_side_t            b_side_reg, b_side_next;

    always_comb
    begin
        logic [CHAN_W-1:0]  chroma;
        logic [CHAN_W:0]    sum;
        logic [LIGHT_W:0]   light_x2;
        chroma   = a_max_reg - a_min_reg;
        sum      = {1'b0, a_max_reg} + {1'b0, a_min_reg};
        light_x2 = {sum, 8'b0} + (LIGHT_W + 1)'(sum);

        b_sat_num_next = {chroma, 16'b0} - DIV_NUM_W'(chroma);
        b_sat_den_next = (sum < (CHAN_W + 1)'(255)) ? DIV_DEN_W'(sum)
                                                   : DIV_DEN_W'(10'd510 - {1'b0, sum});
        b_hue_num_next = DIV_NUM_W'({a_mag_reg, 12'b0}) - DIV_NUM_W'({a_mag_reg, 8'b0});
        b_hue_den_next = DIV_DEN_W'(chroma);

        b_side_next.grey      = (chroma == '0);
        b_side_next.neg       = a_neg_reg;
        b_side_next.sector    = a_sector_reg;
        b_side_next.lightness = light_x2[LIGHT_W:1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= start && !busy;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_max_reg     <= a_max_next;
        a_min_reg     <= a_min_next;
        a_sector_reg  <= a_sector_next;
        a_neg_reg     <= a_neg_next;
        a_mag_reg     <= a_mag_next;
        b_sat_num_reg <= b_sat_num_next;
        b_sat_den_reg <= b_sat_den_next;
        b_hue_num_reg <= b_hue_num_next;
        b_hue_den_reg <= b_hue_den_next;
        b_side_reg    <= b_side_next;
    end

    // ---------------------------------------------------------------------
    // The two divisions run side by side with equal latency. The hue divider
    // carries the sector, sign, grey flag and lightness along; the saturation
    // divider carries only the grey flag, which zeroes its quotient.
    // ---------------------------------------------------------------------
    logic                 hue_div_valid;
    logic [DIV_QUO_W-1:0] hue_quo;
    logic [SIDE_W-1:0]    hue_side_bits;
    hue_side_t            hue_side;
    logic                 sat_div_valid;
    logic [DIV_QUO_W-1:0] sat_quo;
    logic                 sat_grey;

    rgbhsl_div #(
        .NUM_W     (DIV_NUM_W),
        .DEN_W     (DIV_DEN_W),
        .QUO_W     (DIV_QUO_W),
        .STEP_BITS (DIV_STEP_BITS_P),
        .SIDE_W    (SIDE_W)
    ) u_hue_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (b_valid_reg),
        .num       (b_hue_num_reg),
        .den       (b_hue_den_reg),
        .side_in   (b_side_reg),
        .out_valid (hue_div_valid),
        .quo       (hue_quo),
        .side_out  (hue_side_bits)
    );

    rgbhsl_div #(
        .NUM_W     (DIV_NUM_W),
        .DEN_W     (DIV_DEN_W),
        .QUO_W     (DIV_QUO_W),
        .STEP_BITS (DIV_STEP_BITS_P),
        .SIDE_W    (1)
    ) u_sat_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (b_valid_reg),
        .num       (b_sat_num_reg),
        .den       (b_sat_den_reg),
        .side_in   (b_side_reg.grey),
        .out_valid (sat_div_valid),
        .quo       (sat_quo),
        .side_out  (sat_grey)
    );

    assign hue_side = hue_side_t'(hue_side_bits);

    // ---------------------------------------------------------------------
    // Output stage: place the hue quotient in its sector. A negative hue can
    // only arise in the red sector, where it wraps to a full circle minus the
    // quotient. Grey pixels report zero hue and saturation.
    // ---------------------------------------------------------------------
    logic done_reg;
    hsl_t result_reg, result_next;

    always_comb
    begin
        logic [HUE_W-1:0] offset;
        logic [HUE_W-1:0] mag;
        mag = hue_quo[HUE_W-1:0];
        case (hue_side.sector)
            SECT_RED:   offset = hue_side.neg ? HUE_W'(HUE_FULL_CIRCLE) : '0;
            SECT_GREEN: offset = HUE_W'(HUE_GREEN_OFFSET);
            SECT_BLUE:  offset = HUE_W'(HUE_BLUE_OFFSET);
            default:    offset = '0;
        endcase

        result_next.hue        = hue_side.neg ? offset - mag : offset + mag;
        result_next.saturation = sat_quo;
        result_next.lightness  = hue_side.lightness;
        if (hue_side.grey)
        begin
            result_next.hue = '0;
        end
        if (sat_grey)
        begin
            result_next.saturation = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= hue_div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // ---------------------------------------------------------------------
    // Checks.
    // ---------------------------------------------------------------------

    // Both dividers must stay in lockstep, or hue and saturation would pair
    // up with different pixels.
    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        hue_div_valid == sat_div_valid)
        else $error("hue and saturation dividers out of step");

    // Hue always lands inside one full circle.
    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.hue < HUE_W'(HUE_FULL_CIRCLE)))
        else $error("hue outside one circle");

    // Zero saturation only comes from a grey pixel, which has zero hue.
    a_grey_hue: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.saturation == '0) |-> (result.hue == '0))
        else $error("zero saturation with nonzero hue");

    // Every result traces back to a beat that left stage B at the fixed latency.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(b_valid_reg, DIV_STAGES + 1))
        else $error("result without a matching input beat");

endmodule

// ===== rtl/rgbhsl_div.sv =====
// Pipelined restoring divider that retires STEP_BITS quotient bits per stage.
module rgbhsl_div
    import rgbhsl_pkg::*;
#(
    parameter int NUM_W     = DIV_NUM_W,
    parameter int DEN_W     = DIV_DEN_W,
    parameter int QUO_W     = DIV_QUO_W,
    parameter int STEP_BITS = DIV_STEP_BITS,
    parameter int SIDE_W    = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [QUO_W-1:0]  quo,
    output logic [SIDE_W-1:0] side_out
);

    localparam int STAGES = (QUO_W + STEP_BITS - 1) / STEP_BITS;
    localparam int REM_W  = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

    // The quotient must fit in QUO_W bits, so the numerator is below den << QUO_W.
    logic [STAGES-1:0] valid_reg;
    logic [REM_W-1:0]  rem_reg  [STAGES];
    logic [DEN_W-1:0]  den_reg  [STAGES];
    logic [QUO_W-1:0]  quo_reg  [STAGES];
    logic [SIDE_W-1:0] side_reg [STAGES];

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        logic              valid_in;
        logic [REM_W-1:0]  rem_in;
        logic [DEN_W-1:0]  den_in;
        logic [QUO_W-1:0]  quo_in;
        logic [SIDE_W-1:0] side_s;
        logic [REM_W-1:0]  rem_next;
        logic [QUO_W-1:0]  quo_next;

        if (s == 0) begin : g_first
            assign valid_in = in_valid;
            assign rem_in   = REM_W'(num);
            assign den_in   = den;
            assign quo_in   = '0;
            assign side_s   = side_in;
        end
        else begin : g_rest
            assign valid_in = valid_reg[s-1];
            assign rem_in   = rem_reg[s-1];
            assign den_in   = den_reg[s-1];
            assign quo_in   = quo_reg[s-1];
            assign side_s   = side_reg[s-1];
        end

        always_comb
        begin
            logic [REM_W-1:0] rem_v;
            logic [REM_W-1:0] trial;
            logic [QUO_W-1:0] quo_v;
            int               idx;
            rem_v = rem_in;
            quo_v = quo_in;
            for (int j = 0; j < STEP_BITS; j++)
            begin
                idx   = QUO_W - 1 - (s * STEP_BITS + j);
                trial = '0;
                if (idx >= 0)
                begin
                    trial = REM_W'(den_in) << idx;
                    if (rem_v >= trial)
                    begin
                        rem_v = rem_v - trial;
                        quo_v = quo_v | (QUO_W'(1) << idx);
                    end
                end
            end
            rem_next = rem_v;
            quo_next = quo_v;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else
            begin
                valid_reg[s] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s]  <= rem_next;
            den_reg[s]  <= den_in;
            quo_reg[s]  <= quo_next;
            side_reg[s] <= side_s;
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign quo       = quo_reg[STAGES-1];
    assign side_out  = side_reg[STAGES-1];

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the RGB to HSL pixel converter.
module testbench
    import rgbhsl_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Fixed-point scale of saturation and lightness, and the largest channel sum.
    localparam int FRACTION_FULL = 65535;
    localparam int CHAN_SUM_MAX  = 510;
    localparam int CHAN_MAX      = 255;

    // Cycles that may pass with no beat in either direction before the run is
    // declared hung. The slowest legal stretch is a long sender gap plus a full
    // pipeline drain.
    localparam int HANG_LIMIT = 1000;

    // Cycles to keep watching the result port after the last expected beat, so
    // that a stray extra result from the pipeline is still caught.
    localparam int TAIL_CYCLES = 30;

    // Number of random pixels after the directed ones.
    localparam int RANDOM_PIXELS = 1228;

    // Directed pixels, packed as {red, green, blue}. They cover black, white and
    // mid grey, the pure primaries, every two-way tie for the largest channel,
    // a red-sector hue that goes negative and has to wrap, both sides of the
    // boundary where the saturation divisor switches from t to 510 - t, single
    // low bits, and alternating bit patterns on the red and green channels.
    localparam logic [23:0] DIRECTED_PIXELS [22] = '{
        24'h000000, 24'hFFFFFF, 24'h808080, 24'hFF0000, 24'h00FF00, 24'h0000FF,
        24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'hFF0001, 24'hC80A64, 24'hFE0000,
        24'h807F7F, 24'h7F7F80, 24'h010000, 24'h000100, 24'h000001, 24'hFFFE00,
        24'hFEFFFF, 24'hAA550F, 24'h55AAF0, 24'h7F0080
    };

    // One pixel waiting to be sent. When settle_first is set the sender holds
    // off until every result already owed by the converter has come back.
    typedef struct {
        pixel_t px;
        bit     settle_first;
    } pending_pixel_t;

    logic   clk   = 1'b0;
    logic   rst_n = 1'b0;
    logic   start = 1'b0;
    pixel_t pixel = '0;
    logic   busy;
    logic   done;
    hsl_t   result;

    pending_pixel_t pending_pixels [$];
    hsl_t           hsl_expected [$];

    // Beat counters on both sides. They are updated with nonblocking
    // assignments, so any block reading them at a clock edge sees the values
    // from before that edge.
    int accepted_cnt = 0;
    int retired_cnt  = 0;
    int mismatch_cnt = 0;
    int idle_cycles  = 0;

    // Sender pacing: pixels in the current burst, and idle cycles still to
    // insert before the next burst starts.
    int burst_left = 8;
    int gap_left   = 0;

    rgb_to_hsl_converter dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .pixel  (pixel),
        .done   (done),
        .result (result)
    );

    always #1 clk = ~clk;

    // Expected hue, saturation and lightness of one pixel. All arithmetic is
    // carried out in signed 32-bit integers; every intermediate value is far
    // below the overflow point, and signed division truncates toward zero just
    // as the hue definition asks.
    function automatic hsl_t hsl_of(pixel_t px);
        int      r;
        int      g;
        int      b;
        int      hi;
        int      lo;
        int      span;
        int      total;
        int      hue_val;
        sector_t sect;
        hsl_t    res;
        r = int'(px.red);
        g = int'(px.green);
        b = int'(px.blue);
        hi = (r > g) ? r : g;
        hi = (hi > b) ? hi : b;
        lo = (r < g) ? r : g;
        lo = (lo < b) ? lo : b;
        span = hi - lo;
        total = hi + lo;
        res = '0;
        res.lightness = LIGHT_W'((total * FRACTION_FULL) / CHAN_SUM_MAX);
        if (span != 0)
        begin
            // The divisor is the distance of the sum from the nearer end.
            if (total < CHAN_MAX)
                res.saturation = SAT_W'((span * FRACTION_FULL) / total);
            else
                res.saturation = SAT_W'((span * FRACTION_FULL) / (CHAN_SUM_MAX - total));
            // Red wins ties over green, and green wins over blue.
            if (r == hi)
                sect = SECT_RED;
            else if (g == hi)
                sect = SECT_GREEN;
            else
                sect = SECT_BLUE;
            case (sect)
                SECT_RED:
                    hue_val = (int'(HUE_SECTOR_SCALE) * (g - b)) / span;
                SECT_GREEN:
                    hue_val = (int'(HUE_SECTOR_SCALE) * (b - r)) / span
                              + int'(HUE_GREEN_OFFSET);
                default:
                    hue_val = (int'(HUE_SECTOR_SCALE) * (r - g)) / span
                              + int'(HUE_BLUE_OFFSET);
            endcase
            // Only the red sector can go below zero; wrap it by a full circle.
            if (hue_val < 0)
                hue_val = hue_val + int'(HUE_FULL_CIRCLE);
            res.hue = HUE_W'(hue_val);
        end
        return res;
    endfunction

    // Prints one line per mismatch and keeps the count for the verdict.
    task automatic report_mismatch(string what);
        mismatch_cnt = mismatch_cnt + 1;
        $display("[%0t] MISMATCH %s", $realtime, what);
    endtask

    // Driver. At each rising edge it first checks whether the pixel that was on
    // the port has just been taken; if so, the expected result goes into the
    // queue. It then decides what the port carries for the next cycle with a
    // single assignment to start, so a beat that continues a burst never sees
    // start dropped and raised in the same time step. A pixel that was not
    // taken is held unchanged, as the handshake requires.
    always @(posedge clk)
    begin
        pending_pixel_t nxt;
        bit             took;
        int             in_flight;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            took = start && !busy;
            if (took)
            begin
                hsl_expected.push_back(hsl_of(pixel));
                accepted_cnt <= accepted_cnt + 1;
            end
            in_flight = accepted_cnt - retired_cnt + int'(took);
            if (start && !took)
            begin
                // Held off: the same beat stays on the port.
            end
            else if (pending_pixels.size() == 0)
            begin
                start <= 1'b0;
            end
            else if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end
            else if (pending_pixels[0].settle_first && in_flight != 0)
            begin
                // Let the pipeline run dry before this pixel goes out.
                start <= 1'b0;
            end
            else
            begin
                nxt = pending_pixels.pop_front();
                pixel <= nxt.px;
                start <= 1'b1;
                if (burst_left <= 1)
                begin
                    // End of a burst: pick the next burst length and the gap
                    // before it. Many gaps are zero, so long unbroken streams
                    // at the full rate of one pixel per clock also occur.
                    burst_left <= $urandom_range(1, 48);
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: gap_left <= 0;
                        4, 5, 6, 7: gap_left <= $urandom_range(1, 4);
                        8:          gap_left <= $urandom_range(5, 12);
                        default:    gap_left <= $urandom_range(13, 24);
                    endcase
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // Monitor. A result is valid for exactly the one cycle that done marks, and
    // is taken at the rising edge that ends that cycle. Every result is matched
    // against the oldest expectation, one field at a time.
    always @(posedge clk)
    begin
        hsl_t want;
        if (rst_n && done)
        begin
            if (hsl_expected.size() == 0)
            begin
                report_mismatch($sformatf("result with nothing expected: hue %0d sat %0d light %0d",
                                          result.hue, result.saturation, result.lightness));
            end
            else
            begin
                want = hsl_expected.pop_front();
                retired_cnt <= retired_cnt + 1;
                if (result.hue !== want.hue)
                    report_mismatch($sformatf("result %0d hue: got %0d want %0d",
                                              retired_cnt, result.hue, want.hue));
                if (result.saturation !== want.saturation)
                    report_mismatch($sformatf("result %0d saturation: got %0d want %0d",
                                              retired_cnt, result.saturation, want.saturation));
                if (result.lightness !== want.lightness)
                    report_mismatch($sformatf("result %0d lightness: got %0d want %0d",
                                              retired_cnt, result.lightness, want.lightness));
            end
        end
    end

    // Watchdog. Counts cycles in which no beat moves in either direction; a
    // run that stalls for too long is a failure.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= HANG_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Stimulus and verdict. The whole pixel list is built up front; the driver
    // drains it at its own pace once reset is released.
    initial
    begin
        pending_pixel_t item;
        int             hi_val;
        int             lo_val;

        foreach (DIRECTED_PIXELS[i])
        begin
            item.px = DIRECTED_PIXELS[i];
            item.settle_first = 1'b0;
            pending_pixels.push_back(item);
        end

        for (int n = 0; n < RANDOM_PIXELS; n++)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    // Grey: all channels equal, so hue and saturation are zero.
                    hi_val = $urandom_range(0, 255);
                    item.px = '{red: 8'(hi_val), green: 8'(hi_val), blue: 8'(hi_val)};
                end
                1:
                begin
                    // Two channels tie, in a random pair of positions.
                    hi_val = $urandom_range(0, 255);
                    lo_val = $urandom_range(0, hi_val);
                    case ($urandom_range(0, 2))
                        0:       item.px = '{8'(hi_val), 8'(hi_val), 8'(lo_val)};
                        1:       item.px = '{8'(hi_val), 8'(lo_val), 8'(hi_val)};
                        default: item.px = '{8'(lo_val), 8'(hi_val), 8'(hi_val)};
                    endcase
                end
                2:
                begin
                    // Channels at or next to the ends of their range.
                    item.px.red   = $urandom_range(0, 1) ? 8'(255 - $urandom_range(0, 1))
                                                         : 8'($urandom_range(0, 1));
                    item.px.green = $urandom_range(0, 1) ? 8'(255 - $urandom_range(0, 1))
                                                         : 8'($urandom_range(0, 1));
                    item.px.blue  = $urandom_range(0, 1) ? 8'(255 - $urandom_range(0, 1))
                                                         : 8'($urandom_range(0, 1));
                end
                3:
                begin
                    // Channel sums close to 255, where the saturation divisor
                    // changes from the sum to its distance from 510.
                    item.px.red   = 8'($urandom_range(118, 137));
                    item.px.green = 8'($urandom_range(118, 137));
                    item.px.blue  = 8'($urandom_range(118, 137));
                end
                default:
                begin
                    item.px = pixel_t'($urandom);
                end
            endcase
            // The first random pixel, and about one in a hundred after it,
            // waits for the pipeline to empty before it is sent.
            item.settle_first = (n == 0) || ($urandom_range(0, 99) == 0);
            pending_pixels.push_back(item);
        end

        // Reset is held low from the start and released once, on a clock edge.
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every pixel has been taken and every result has come back.
        while (pending_pixels.size() != 0 || start || accepted_cnt != retired_cnt)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_cnt == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
